>>> src/xid_pkg.sv
// Shared types, byte codes and the window byte read for the instruction decoder.
package xid_pkg;

    localparam int WindowBytes = 15;

    localparam logic [7:0] OpOpsz   = 8'h66;
    localparam logic [7:0] OpAdsz   = 8'h67;
    localparam logic [7:0] OpLock   = 8'hF0;
    localparam logic [7:0] OpRepne  = 8'hF2;
    localparam logic [7:0] OpRep    = 8'hF3;
    localparam logic [7:0] OpSegFs  = 8'h64;
    localparam logic [7:0] OpSegGs  = 8'h65;
    localparam logic [7:0] OpSegCs  = 8'h2E;
    localparam logic [7:0] OpSegSs  = 8'h36;
    localparam logic [7:0] OpSegDs  = 8'h3E;
    localparam logic [7:0] OpSegEs  = 8'h26;
    localparam logic [7:0] OpVex2   = 8'hC5;
    localparam logic [7:0] OpVex3   = 8'hC4;
    localparam logic [7:0] OpEvex   = 8'h62;
    localparam logic [7:0] OpEsc    = 8'h0F;
    localparam logic [7:0] OpEsc38  = 8'h38;
    localparam logic [7:0] OpEsc3A  = 8'h3A;
    localparam logic [7:0] OpVzero  = 8'h77;

    localparam logic [1:0] Osz16 = 2'd0;
    localparam logic [1:0] Osz32 = 2'd1;
    localparam logic [1:0] Osz64 = 2'd2;

    localparam logic [1:0] Map38 = 2'd2;
    localparam logic [1:0] Map3A = 2'd3;

    localparam logic [1:0] StOk   = 2'd0;
    localparam logic [1:0] StMore = 2'd1;
    localparam logic [1:0] StLong = 2'd2;

    typedef logic [WindowBytes-1:0][7:0] win_t;

    // After prefix scan
    typedef struct packed {
        win_t       win;
        logic [3:0] vbytes;
        logic [5:0] pos;
        logic       p66;
        logic       a32;
        logic       lk;
        logic       rne;
        logic       rp;
        logic [1:0] seg;
    } pre_t;

    // After lead bytes and opcode
    typedef struct packed {
        win_t       win;
        logic [3:0] vbytes;
        logic [5:0] pos;
        logic [7:0] op;
        logic       esc;
        logic [1:0] legacy3;
        logic       vx;
        logic       ev;
        logic       hrex;
        logic       r_r;
        logic       r_x;
        logic       r_b;
        logic [4:0] vmap;
        logic       vw;
        logic [4:0] vvvv;
        logic [1:0] vl;
        logic [1:0] pp;
        logic       vz;
        logic       vb;
        logic [2:0] vmask;
        logic [1:0] osz;
        logic       p66;
        logic       a32;
        logic       lk;
        logic       rne;
        logic       rp;
        logic [1:0] seg;
    } lead_t;

    // After ModRM, SIB and displacement
    typedef struct packed {
        lead_t       ld;
        logic [2:0]  regf;
        logic [13:0] modrm_f;
        logic [13:0] mem_f;
        logic [31:0] disp;
    } mrm_t;

    // Read one byte; positions past the window read as zero
    function automatic logic [7:0] rd_byte(win_t w, logic [5:0] i);
        logic [7:0] b;
        b = 8'h00;
        if (i < 6'(WindowBytes))
        begin
            b = w[i[3:0]];
        end
        return b;
    endfunction

endpackage

>>> src/x86_64_instruction_decoder.sv
// Top level of the four-stage x86-64 instruction length decoder.
//
// channel | direction | handshake            | payload
// --------+-----------+----------------------+---------------------------------------------
// in      | input     | in_valid / in_ready  | window_low, window_high, valid_bytes
// out     | output    | out_valid / out_ready| length, status, opcode ... vector_fields
//
// Four registered stages: prefix scan, lead/opcode, ModRM/SIB/disp, immediate/output.
// One word enters per cycle while in_ready is high; each stage holds its own valid bit.
// A stage's ready is its own emptiness or the next stage's ready, so bubbles close up.
// Reset clears the stage valid bits only.
module x86_64_instruction_decoder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [63:0]        window_low,
    input  logic [55:0]        window_high,
    input  logic [3:0]         valid_bytes,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [3:0]         length,
    output logic [1:0]         status,
    output logic [7:0]         opcode,
    output logic [4:0]         opcode_map,
    output logic [9:0]         prefix_flags,
    output logic [1:0]         operand_size,
    output logic [13:0]        modrm_fields,
    output logic [13:0]        memory_fields,
    output logic signed [31:0] displacement,
    output logic signed [63:0] immediate,
    output logic [3:0]         imm_size,
    output logic [14:0]        vector_fields
);
    import xid_pkg::*;

    win_t  win;
    pre_t  pre_d;
    lead_t lead_d;
    mrm_t  mrm_d;
    logic  pre_v, pre_r, lead_v, lead_r, mrm_v, mrm_r;

    assign win = {window_high, window_low};

    xid_prefix u_prefix (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_win    (win),
        .in_vbytes (valid_bytes),
        .out_valid (pre_v),
        .out_ready (pre_r),
        .out_data  (pre_d)
    );

    xid_lead u_lead (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pre_v),
        .in_ready  (pre_r),
        .in_data   (pre_d),
        .out_valid (lead_v),
        .out_ready (lead_r),
        .out_data  (lead_d)
    );

    xid_modrm u_modrm (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (lead_v),
        .in_ready  (lead_r),
        .in_data   (lead_d),
        .out_valid (mrm_v),
        .out_ready (mrm_r),
        .out_data  (mrm_d)
    );

    xid_imm u_imm (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (mrm_v),
        .in_ready      (mrm_r),
        .in_data       (mrm_d),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .length        (length),
        .status        (status),
        .opcode        (opcode),
        .opcode_map    (opcode_map),
        .prefix_flags  (prefix_flags),
        .operand_size  (operand_size),
        .modrm_fields  (modrm_fields),
        .memory_fields (memory_fields),
        .displacement  (displacement),
        .immediate     (immediate),
        .imm_size      (imm_size),
        .vector_fields (vector_fields)
    );

`ifndef SYNTHESIS
    a_long_caps: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == StLong |-> length == 4'd15)
        else $error("overlong word without capped length");
    a_imm_size: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> imm_size == 4'd0 || imm_size == 4'd1 || imm_size == 4'd2
                      || imm_size == 4'd4 || imm_size == 4'd8)
        else $error("bad immediate size");
    a_mem_modrm: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && memory_fields[0] |-> modrm_fields[0] && modrm_fields[2:1] != 2'd3)
        else $error("memory operand without memory ModRM");
    a_legacy_vec: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !prefix_flags[8] |-> vector_fields == 15'd0 && !prefix_flags[9])
        else $error("vector fields set on legacy code");
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(immediate) && $stable(length))
        else $error("output word changed under stall");
`endif

endmodule

>>> src/xid_prefix.sv
// Stage 1: byte masking and legacy prefix scan.
module xid_prefix (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  xid_pkg::win_t      in_win,
    input  logic [3:0]         in_vbytes,
    output logic               out_valid,
    input  logic               out_ready,
    output xid_pkg::pre_t      out_data
);
    import xid_pkg::*;

    logic valid_reg;
    pre_t data_reg;
    pre_t data_next;

    // Zero unfetched bytes, then consume prefixes while they last
    always_comb
    begin
        logic found;
        logic [7:0] b;
        data_next = '0;
        found = 1'b0;
        data_next.vbytes = in_vbytes;
        data_next.pos = 6'(WindowBytes);
        for (int i = 0; i < WindowBytes; i++)
        begin
            data_next.win[i] = (4'(i) < in_vbytes) ? in_win[i] : 8'h00;
        end
        for (int i = 0; i < WindowBytes; i++)
        begin
            b = data_next.win[i];
            if (!found)
            begin
                if (b == OpOpsz) data_next.p66 = 1'b1;
                else if (b == OpAdsz) data_next.a32 = 1'b1;
                else if (b == OpLock) data_next.lk = 1'b1;
                else if (b == OpRepne) data_next.rne = 1'b1;
                else if (b == OpRep) data_next.rp = 1'b1;
                else if (b == OpSegFs) data_next.seg = 2'd1;
                else if (b == OpSegGs) data_next.seg = 2'd2;
                else if (b == OpSegCs || b == OpSegSs || b == OpSegDs || b == OpSegEs)
                begin
                    found = 1'b0;
                end
                else
                begin
                    found = 1'b1;
                    data_next.pos = 6'(i);
                end
            end
        end
    end

    assign in_ready = !valid_reg || out_ready;

    // Advance the stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Capture the word
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> src/xid_lead.sv
// Stage 2: VEX, EVEX, REX and escape decode up to the opcode byte.
module xid_lead (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  xid_pkg::pre_t      in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output xid_pkg::lead_t     out_data
);
    import xid_pkg::*;

    logic  valid_reg;
    lead_t data_reg;
    lead_t data_next;

    // Decode the lead bytes at the first non-prefix position
    always_comb
    begin
        logic [7:0] b0, b1, b2, b3, op0, op1;
        logic [5:0] n, p;
        logic       rw;
        n  = in_data.pos;
        b0 = rd_byte(in_data.win, n);
        b1 = rd_byte(in_data.win, n + 6'd1);
        b2 = rd_byte(in_data.win, n + 6'd2);
        b3 = rd_byte(in_data.win, n + 6'd3);
        p  = n;
        rw = 1'b0;
        op0 = 8'h00;
        op1 = 8'h00;
        data_next = '0;
        data_next.win    = in_data.win;
        data_next.vbytes = in_data.vbytes;
        data_next.a32    = in_data.a32;
        data_next.lk     = in_data.lk;
        data_next.rne    = in_data.rne;
        data_next.rp     = in_data.rp;
        data_next.seg    = in_data.seg;
        priority if (b0 == OpVex2)
        begin
            data_next.vx   = 1'b1;
            data_next.esc  = 1'b1;
            data_next.r_r  = ~b1[7];
            data_next.vvvv = {1'b0, ~b1[6:3]};
            data_next.vl   = {1'b0, b1[2]};
            data_next.pp   = b1[1:0];
            data_next.vmap = 5'd1;
            data_next.op   = rd_byte(in_data.win, n + 6'd2);
            data_next.pos  = n + 6'd3;
        end
        else if (b0 == OpVex3)
        begin
            data_next.vx   = 1'b1;
            data_next.esc  = 1'b1;
            data_next.r_r  = ~b1[7];
            data_next.r_x  = ~b1[6];
            data_next.r_b  = ~b1[5];
            data_next.vmap = b1[4:0];
            data_next.vw   = b2[7];
            data_next.vvvv = {1'b0, ~b2[6:3]};
            data_next.vl   = {1'b0, b2[2]};
            data_next.pp   = b2[1:0];
            data_next.op   = rd_byte(in_data.win, n + 6'd3);
            data_next.pos  = n + 6'd4;
        end
        else if (b0 == OpEvex)
        begin
            data_next.vx    = 1'b1;
            data_next.ev    = 1'b1;
            data_next.esc   = 1'b1;
            data_next.r_r   = ~b1[7];
            data_next.r_x   = ~b1[6];
            data_next.r_b   = ~b1[5];
            data_next.vmap  = {3'b000, b1[1:0]};
            data_next.vw    = b2[7];
            data_next.vvvv  = {~b3[3], ~b2[6:3]};
            data_next.pp    = b2[1:0];
            data_next.vl    = b3[6:5];
            data_next.vz    = b3[7];
            data_next.vb    = b3[4];
            data_next.vmask = b3[2:0];
            data_next.op    = rd_byte(in_data.win, n + 6'd4);
            data_next.pos   = n + 6'd5;
        end
        else
        begin
            // Optional REX, then the escape bytes
            if (b0[7:4] == 4'h4)
            begin
                data_next.hrex = 1'b1;
                rw = b0[3];
                data_next.r_r = b0[2];
                data_next.r_x = b0[1];
                data_next.r_b = b0[0];
                p = n + 6'd1;
            end
            op0 = rd_byte(in_data.win, p);
            op1 = rd_byte(in_data.win, p + 6'd1);
            data_next.op  = op0;
            data_next.pos = p + 6'd1;
            if (op0 == OpEsc)
            begin
                data_next.esc = 1'b1;
                data_next.op  = op1;
                data_next.pos = p + 6'd2;
                if (op1 == OpEsc38 || op1 == OpEsc3A)
                begin
                    data_next.legacy3 = (op1 == OpEsc38) ? Map38 : Map3A;
                    data_next.op  = rd_byte(in_data.win, p + 6'd2);
                    data_next.pos = p + 6'd3;
                end
            end
        end
        data_next.p66 = in_data.p66 || (data_next.vx && data_next.pp == 2'd1);
        data_next.osz = (rw || data_next.vw) ? Osz64 : (in_data.p66 ? Osz16 : Osz32);
    end

    assign in_ready = !valid_reg || out_ready;

    // Advance the stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Capture the word
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> src/xid_modrm.sv
// Stage 3: ModRM, SIB and displacement decode.
module xid_modrm (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  xid_pkg::lead_t     in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output xid_pkg::mrm_t      out_data
);
    import xid_pkg::*;

    logic valid_reg;
    mrm_t data_reg;
    mrm_t data_next;

    function automatic logic needs_modrm(logic esc, logic [7:0] op);
        logic r;
        r = 1'b1;
        if (esc)
        begin
            if (op == 8'h05 || op == 8'hA2 || op == 8'h31 || op == 8'h77) r = 1'b0;
            if (op >= 8'hC8 && op <= 8'hCF) r = 1'b0;
            if (op[7:4] == 4'h8) r = 1'b0;
        end
        else
        begin
            if (op >= 8'h50 && op <= 8'h7F && op[7:4] != 4'h6) r = 1'b0;
            if (op == 8'hE8 || op == 8'hE9 || op == 8'hEB || op == 8'hE3) r = 1'b0;
            if (op >= 8'hE0 && op <= 8'hE2) r = 1'b0;
            if (op == 8'hC3 || op == 8'hC2 || op == 8'hC9 || op == 8'hF4) r = 1'b0;
            if (op >= 8'h90 && op <= 8'h99) r = 1'b0;
            if (op >= 8'h9B && op <= 8'hBF) r = 1'b0;
            if (op == 8'hFC || op == 8'hFD || op == 8'hCC || op == 8'hF5) r = 1'b0;
            if (op == 8'hF8 || op == 8'hF9) r = 1'b0;
            if (op < 8'h40 && (op[2:0] == 3'd4 || op[2:0] == 3'd5)) r = 1'b0;
            if (op == 8'h68 || op == 8'h6A || op == 8'hF1 || op == 8'hD7) r = 1'b0;
        end
        return r;
    endfunction

    // Decode the operand bytes that follow the opcode
    always_comb
    begin
        logic [7:0] m, s, db;
        logic [5:0] n, p;
        logic       need, hasm, ismem, rip, hbase, hidx, vsib;
        logic [1:0] md, scale;
        logic [3:0] regf, rmreg, base, idx;
        logic [2:0] rm;
        logic [31:0] d;
        n = in_data.pos;
        m = rd_byte(in_data.win, n);
        s = rd_byte(in_data.win, n + 6'd1);
        db = 8'h00;
        need = in_data.vx ? (in_data.op != OpVzero)
             : ((in_data.legacy3 != 2'd0) || needs_modrm(in_data.esc, in_data.op));
        hasm = 1'b0; ismem = 1'b0; rip = 1'b0; hbase = 1'b0; hidx = 1'b0;
        md = 2'd0; scale = 2'd0; regf = 4'd0; rmreg = 4'd0; base = 4'd0; idx = 4'd0;
        rm = 3'd0; d = 32'd0; p = n;
        vsib = in_data.vx && in_data.vmap == 5'd2 && in_data.op >= 8'h90
            && in_data.op <= 8'h93;
        if (need)
        begin
            hasm = 1'b1;
            md   = m[7:6];
            regf = {in_data.r_r, m[5:3]};
            rm   = m[2:0];
            p    = n + 6'd1;
            if (md == 2'd3)
            begin
                rmreg = {in_data.r_b, rm};
            end
            else
            begin
                ismem = 1'b1;
                if (rm == 3'd4)
                begin
                    p = n + 6'd2;
                    if (!(s[5:3] == 3'd4 && !in_data.r_x && !vsib))
                    begin
                        hidx  = 1'b1;
                        idx   = {in_data.r_x, s[5:3]};
                        scale = s[7:6];
                    end
                    if (!(s[2:0] == 3'd5 && md == 2'd0))
                    begin
                        hbase = 1'b1;
                        base  = {in_data.r_b, s[2:0]};
                    end
                end
                else if (rm == 3'd5 && md == 2'd0)
                begin
                    rip = 1'b1;
                end
                else
                begin
                    hbase = 1'b1;
                    base  = {in_data.r_b, rm};
                end
                if (md == 2'd1)
                begin
                    db = rd_byte(in_data.win, p);
                    d  = {{24{db[7]}}, db};
                    p  = p + 6'd1;
                end
                else if (rip || md == 2'd2 || (!hbase && rm == 3'd4))
                begin
                    d = {rd_byte(in_data.win, p + 6'd3), rd_byte(in_data.win, p + 6'd2),
                         rd_byte(in_data.win, p + 6'd1), rd_byte(in_data.win, p)};
                    p = p + 6'd4;
                end
            end
        end
        data_next.ld      = in_data;
        data_next.ld.pos  = p;
        data_next.regf    = regf[2:0];
        data_next.modrm_f = {rmreg, rm, regf, md, hasm};
        data_next.mem_f   = {scale, idx, hidx, base, hbase, rip, ismem};
        data_next.disp    = d;
    end

    assign in_ready = !valid_reg || out_ready;

    // Advance the stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Capture the word
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> src/xid_imm.sv
// Stage 4: immediate size and value, length, status and the output register.
module xid_imm (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  xid_pkg::mrm_t      in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [3:0]         length,
    output logic [1:0]         status,
    output logic [7:0]         opcode,
    output logic [4:0]         opcode_map,
    output logic [9:0]         prefix_flags,
    output logic [1:0]         operand_size,
    output logic [13:0]        modrm_fields,
    output logic [13:0]        memory_fields,
    output logic signed [31:0] displacement,
    output logic signed [63:0] immediate,
    output logic [3:0]         imm_size,
    output logic [14:0]        vector_fields
);
    import xid_pkg::*;

    typedef struct packed {
        logic [3:0]  len;
        logic [1:0]  st;
        logic [7:0]  op;
        logic [4:0]  map;
        logic [9:0]  pfx;
        logic [1:0]  osz;
        logic [13:0] modrm_f;
        logic [13:0] mem_f;
        logic [31:0] disp;
        logic [63:0] imm;
        logic [3:0]  ib;
        logic [14:0] vec_f;
    } res_t;

    logic valid_reg;
    res_t data_reg;
    res_t data_next;

    function automatic logic [3:0] imm_len(lead_t l, logic [2:0] regf);
        logic [3:0] iz, r;
        logic       sse;
        logic [7:0] op;
        op  = l.op;
        iz  = (l.osz == Osz16) ? 4'd2 : 4'd4;
        sse = (op >= 8'h70 && op <= 8'h73) || op == 8'hC2 || (op >= 8'hC4 && op <= 8'hC6);
        r   = 4'd0;
        if (l.legacy3 != 2'd0)
        begin
            r = (l.legacy3 == Map3A) ? 4'd1 : 4'd0;
        end
        else if (l.vx)
        begin
            if (l.vmap == 5'd3 || (l.vmap == 5'd1 && sse)) r = 4'd1;
        end
        else if (l.esc)
        begin
            if (op[7:4] == 4'h8) r = 4'd4;
            else if (op == 8'hBA || op == 8'hA4 || op == 8'hAC || sse) r = 4'd1;
        end
        else
        begin
            priority if (op == 8'hC2) r = 4'd2;
            else if (op >= 8'h70 && op <= 8'h7F) r = 4'd1;
            else if (op == 8'hEB || op == 8'hE3 || (op >= 8'hE0 && op <= 8'hE2)) r = 4'd1;
            else if (op == 8'hE9 || op == 8'hE8) r = 4'd4;
            else if (op >= 8'hA0 && op <= 8'hA3) r = l.a32 ? 4'd4 : 4'd8;
            else if (op >= 8'hB0 && op <= 8'hB7) r = 4'd1;
            else if (op >= 8'hB8 && op <= 8'hBF) r = (l.osz == Osz64) ? 4'd8 : iz;
            else if (op < 8'h40 && op[2:0] == 3'd4) r = 4'd1;
            else if (op < 8'h40 && op[2:0] == 3'd5) r = iz;
            else if (op == 8'hA8 || op == 8'h6A || op == 8'h80 || op == 8'h83
                     || op == 8'hC6 || op == 8'hC0 || op == 8'hC1 || op == 8'h6B) r = 4'd1;
            else if (op == 8'hA9 || op == 8'h68 || op == 8'h81 || op == 8'hC7
                     || op == 8'h69) r = iz;
            else if (op == 8'hF6) r = (regf <= 3'd1) ? 4'd1 : 4'd0;
            else if (op == 8'hF7) r = (regf <= 3'd1) ? iz : 4'd0;
            else r = 4'd0;
        end
        return r;
    endfunction

    // Gather the immediate, sign-extend it and close out the length
    always_comb
    begin
        lead_t       l;
        logic [3:0]  ib;
        logic [63:0] raw, imm;
        logic [5:0]  n;
        l   = in_data.ld;
        ib  = imm_len(l, in_data.regf);
        raw = '0;
        for (int i = 0; i < 8; i++)
        begin
            raw[8*i +: 8] = rd_byte(l.win, l.pos + 6'(i));
        end
        unique case (ib)
            4'd1:    imm = {{56{raw[7]}}, raw[7:0]};
            4'd2:    imm = {{48{raw[15]}}, raw[15:0]};
            4'd4:    imm = {{32{raw[31]}}, raw[31:0]};
            4'd8:    imm = raw;
            default: imm = 64'd0;
        endcase
        n = l.pos + {2'b00, ib};
        data_next.ib  = ib;
        data_next.imm = imm;
        if (n > 6'd15)
        begin
            data_next.len = 4'd15;
            data_next.st  = StLong;
        end
        else
        begin
            data_next.len = n[3:0];
            data_next.st  = (n[3:0] > l.vbytes) ? StMore : StOk;
        end
        data_next.op      = l.op;
        data_next.map     = l.vx ? l.vmap
                          : (l.esc ? ((l.legacy3 != 2'd0) ? {3'b000, l.legacy3} : 5'd1) : 5'd0);
        data_next.pfx     = {l.ev, l.vx, l.hrex, l.seg, l.rp, l.rne, l.lk, l.a32, l.p66};
        data_next.osz     = l.osz;
        data_next.modrm_f = in_data.modrm_f;
        data_next.mem_f   = in_data.mem_f;
        data_next.disp    = in_data.disp;
        data_next.vec_f   = {l.vmask, l.vb, l.vz, l.vw, l.pp, l.vl, l.vvvv};
    end

    assign in_ready = !valid_reg || out_ready;

    // Advance the output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Capture the word
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid     = valid_reg;
    assign length        = data_reg.len;
    assign status        = data_reg.st;
    assign opcode        = data_reg.op;
    assign opcode_map    = data_reg.map;
    assign prefix_flags  = data_reg.pfx;
    assign operand_size  = data_reg.osz;
    assign modrm_fields  = data_reg.modrm_f;
    assign memory_fields = data_reg.mem_f;
    assign displacement  = data_reg.disp;
    assign immediate     = data_reg.imm;
    assign imm_size      = data_reg.ib;
    assign vector_fields = data_reg.vec_f;

endmodule
